### rtl/ttpc_pkg.sv
// Package for the thrust to PWM curve block: field widths, register map codes,
// segment codes and divider sizing. No dependencies.
`default_nettype none

package ttpc_pkg;

   // Field widths
   localparam int CH_W     = 3;   // motor index / channel
   localparam int THRUST_W = 20;  // signed Q15.4 thrust and breakpoints
   localparam int DUTY_W   = 16;  // unsigned duty
   localparam int X_W      = THRUST_W + 1;  // negated thrust, exact for the most negative input
   localparam int DIFF_W   = X_W + 1;       // difference of two X_W values
   localparam int SPAN_W   = THRUST_W;      // segment span and offset inside a segment
   localparam int CURVE_W  = 18;  // signed duty end points (median +/- half range)
   localparam int DELTA_W  = CURVE_W + 1;   // end point difference
   localparam int PROD_W   = DELTA_W + SPAN_W + 1;
   localparam int NUM_W    = 40;  // biased numerator, always below divisor << QUO_W
   localparam int DVS_W    = SPAN_W + 1;    // divisor 2 * span
   localparam int QUO_W    = 19;  // biased quotient, one bit per divider stage
   localparam int RES_W    = 22;  // signed duty before mirror and clamp

   // Quotient bias that keeps the numerator positive
   localparam logic signed [RES_W-1:0] QUO_BIAS = RES_W'(1) <<< (QUO_W - 1);

   // Configuration port
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // Register indexes
   localparam logic [2:0] REG_THRUST_BREAK_0   = 3'd0;
   localparam logic [2:0] REG_THRUST_BREAK_1   = 3'd1;
   localparam logic [2:0] REG_THRUST_BREAK_2   = 3'd2;
   localparam logic [2:0] REG_THRUST_BREAK_3   = 3'd3;
   localparam logic [2:0] REG_DUTY_AT_BREAK_1  = 3'd4;
   localparam logic [2:0] REG_DUTY_NEG_AT_ZERO = 3'd5;
   localparam logic [2:0] REG_DUTY_POS_AT_ZERO = 3'd6;
   localparam logic [2:0] REG_DUTY_AT_BREAK_2  = 3'd7;

   // Register reset values
   localparam logic signed [THRUST_W-1:0] BREAK_0_RST = -20'sd24000;
   localparam logic signed [THRUST_W-1:0] BREAK_1_RST = -20'sd12000;
   localparam logic signed [THRUST_W-1:0] BREAK_2_RST = 20'sd12000;
   localparam logic signed [THRUST_W-1:0] BREAK_3_RST = 20'sd24000;
   localparam logic [DUTY_W-1:0] DUTY_B1_RST = 16'd2500;
   localparam logic [DUTY_W-1:0] DUTY_N0_RST = 16'd3000;
   localparam logic [DUTY_W-1:0] DUTY_P0_RST = 16'd3000;
   localparam logic [DUTY_W-1:0] DUTY_B2_RST = 16'd3500;

   // Curve segment selected for one transaction
   typedef enum logic [2:0] {
      SEG_MEDIAN,    // zero thrust or channel out of range
      SEG_LOW,       // at or below the lowest breakpoint
      SEG_NEG_OUT,   // between breakpoints 0 and 1
      SEG_NEG_IN,    // between breakpoint 1 and zero
      SEG_POS_IN,    // between zero and breakpoint 2
      SEG_POS_OUT,   // between breakpoints 2 and 3
      SEG_HIGH       // at or above the highest breakpoint
   } seg_type;

endpackage

`default_nettype wire

### rtl/thrust_to_pwm_curve.sv
// Thrust to PWM curve: negation, segment select, line set-up, multiply,
// a one-bit-per-stage restoring divider and the mirror/clamp output stage.
// Depends on ttpc_pkg.
//
//   port group  direction  contents
//   req_*       in         tdata[2:0] motor_index, tdata[22:3] thrust
//   rsp_*       out        tdata[2:0] channel, tdata[18:3] compare_value
//   csr_*       in/out     eight configuration registers at byte addresses 4*i
//
// One transaction enters per cycle while the result is not held; each passes
// 25 register stages (five set-up, 19 divider, one output) from acceptance to
// rsp_tvalid, the first of them loaded at the accepting edge.
// All stages move on one shared enable, so a held result freezes the whole pipe
// and nothing is lost or repeated. Synchronous active-high reset clears the valid
// bits and loads the register defaults.
`default_nettype none

module thrust_to_pwm_curve #(
   parameter int MEDIAN_DUTY    = 3000,
   parameter int HALF_RANGE_NEG = 1000,
   parameter int HALF_RANGE_POS = 1000,
   parameter int NUM_MOTORS     = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request stream
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [23:0]                   req_tdata,   // motor_index, thrust, pad
   // result stream
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [23:0]                        rsp_tdata,   // channel, compare_value, pad
   // configuration port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [ttpc_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [ttpc_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [ttpc_pkg::DATA_W-1:0]        csr_prdata,
   output logic                               csr_pready
);

   import ttpc_pkg::*;

   // Curve constants from the parameters
   localparam logic signed [CURVE_W-1:0] MED_DUTY = CURVE_W'(MEDIAN_DUTY);
   localparam logic signed [CURVE_W-1:0] LO_DUTY  = CURVE_W'(MEDIAN_DUTY - HALF_RANGE_NEG);
   localparam logic signed [CURVE_W-1:0] HI_DUTY  = CURVE_W'(MEDIAN_DUTY + HALF_RANGE_POS);
   localparam logic signed [RES_W-1:0]   MIRROR2  = RES_W'(2 * MEDIAN_DUTY);
   localparam logic [CH_W+1:0]           NUM_CH   = (CH_W+2)'(NUM_MOTORS);

   //==========================================================================
   // Configuration registers
   //==========================================================================
   logic signed [THRUST_W-1:0] brk0_ff, brk1_ff, brk2_ff, brk3_ff;
   logic [DUTY_W-1:0]          duty_b1_ff, duty_n0_ff, duty_p0_ff, duty_b2_ff;
   logic                       csr_wr;
   logic [2:0]                 csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   // Write one register per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         brk0_ff    <= BREAK_0_RST;
         brk1_ff    <= BREAK_1_RST;
         brk2_ff    <= BREAK_2_RST;
         brk3_ff    <= BREAK_3_RST;
         duty_b1_ff <= DUTY_B1_RST;
         duty_n0_ff <= DUTY_N0_RST;
         duty_p0_ff <= DUTY_P0_RST;
         duty_b2_ff <= DUTY_B2_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_THRUST_BREAK_0:   brk0_ff    <= csr_pwdata[THRUST_W-1:0];
            REG_THRUST_BREAK_1:   brk1_ff    <= csr_pwdata[THRUST_W-1:0];
            REG_THRUST_BREAK_2:   brk2_ff    <= csr_pwdata[THRUST_W-1:0];
            REG_THRUST_BREAK_3:   brk3_ff    <= csr_pwdata[THRUST_W-1:0];
            REG_DUTY_AT_BREAK_1:  duty_b1_ff <= csr_pwdata[DUTY_W-1:0];
            REG_DUTY_NEG_AT_ZERO: duty_n0_ff <= csr_pwdata[DUTY_W-1:0];
            REG_DUTY_POS_AT_ZERO: duty_p0_ff <= csr_pwdata[DUTY_W-1:0];
            REG_DUTY_AT_BREAK_2:  duty_b2_ff <= csr_pwdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back, breakpoints sign extended
   always_comb begin
      case (csr_idx)
         REG_THRUST_BREAK_0:   csr_prdata = DATA_W'(brk0_ff);
         REG_THRUST_BREAK_1:   csr_prdata = DATA_W'(brk1_ff);
         REG_THRUST_BREAK_2:   csr_prdata = DATA_W'(brk2_ff);
         REG_THRUST_BREAK_3:   csr_prdata = DATA_W'(brk3_ff);
         REG_DUTY_AT_BREAK_1:  csr_prdata = {{(DATA_W-DUTY_W){1'b0}}, duty_b1_ff};
         REG_DUTY_NEG_AT_ZERO: csr_prdata = {{(DATA_W-DUTY_W){1'b0}}, duty_n0_ff};
         REG_DUTY_POS_AT_ZERO: csr_prdata = {{(DATA_W-DUTY_W){1'b0}}, duty_p0_ff};
         REG_DUTY_AT_BREAK_2:  csr_prdata = {{(DATA_W-DUTY_W){1'b0}}, duty_b2_ff};
         default:              csr_prdata = '0;
      endcase
   end

   //==========================================================================
   // Pipeline control: one enable for every stage
   //==========================================================================
   logic advance;
   logic out_vld_ff;

   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;

   //==========================================================================
   // Stage 1: negate the thrust
   //==========================================================================
   logic signed [THRUST_W-1:0] req_thrust;
   logic [CH_W-1:0]            req_ch;
   logic signed [X_W-1:0]      x1_in, x1_ff;
   logic [CH_W-1:0]            ch1_ff;
   logic                       vld1_ff;

   assign req_ch     = req_tdata[CH_W-1:0];
   assign req_thrust = req_tdata[CH_W +: THRUST_W];
   assign x1_in      = -$signed({req_thrust[THRUST_W-1], req_thrust});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (advance) begin
         vld1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff  <= x1_in;
         ch1_ff <= req_ch;
      end
   end

   //==========================================================================
   // Stage 2: pick the segment, tests in priority order
   //==========================================================================
   logic signed [X_W-1:0] b0_x, b1_x, b2_x, b3_x;
   logic                  ch_ok;
   seg_type               seg2_in, seg2_ff;
   logic                  mir2_in, mir2_ff;
   logic signed [X_W-1:0] x2_ff;
   logic [CH_W-1:0]       ch2_ff;
   logic                  vld2_ff;

   assign b0_x  = {brk0_ff[THRUST_W-1], brk0_ff};
   assign b1_x  = {brk1_ff[THRUST_W-1], brk1_ff};
   assign b2_x  = {brk2_ff[THRUST_W-1], brk2_ff};
   assign b3_x  = {brk3_ff[THRUST_W-1], brk3_ff};
   assign ch_ok = {2'b00, ch1_ff} < NUM_CH;

   always_comb begin
      mir2_in = ch_ok && ch1_ff[0];
      if (!ch_ok || x1_ff == '0) begin
         seg2_in = SEG_MEDIAN;
      end else if (x1_ff <= b0_x) begin
         seg2_in = SEG_LOW;
      end else if (x1_ff <= b1_x) begin
         seg2_in = SEG_NEG_OUT;
      end else if (x1_ff[X_W-1]) begin
         seg2_in = SEG_NEG_IN;
      end else if (x1_ff <= b2_x) begin
         seg2_in = SEG_POS_IN;
      end else if (x1_ff < b3_x) begin
         seg2_in = SEG_POS_OUT;
      end else begin
         seg2_in = SEG_HIGH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (advance) begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seg2_ff <= seg2_in;
         mir2_ff <= mir2_in;
         x2_ff   <= x1_ff;
         ch2_ff  <= ch1_ff;
      end
   end

   //==========================================================================
   // Stage 3: segment end points, offset, span and rise
   //==========================================================================
   logic signed [X_W-1:0]     sx, ex;
   logic signed [CURVE_W-1:0] sy, ey;
   logic                      interp;
   logic signed [DIFF_W-1:0]  t_full, s_full;
   logic [SPAN_W-1:0]         t3_in, s3_in, t3_ff, s3_ff;
   logic signed [DELTA_W-1:0] dy3_in, dy3_ff;
   logic signed [CURVE_W-1:0] sy3_ff;
   logic                      mir3_ff;
   logic [CH_W-1:0]           ch3_ff;
   logic                      vld3_ff;

   always_comb begin
      sx     = '0;
      ex     = '0;
      interp = 1'b1;
      case (seg2_ff)
         SEG_NEG_OUT: begin
            sx = b0_x;
            ex = b1_x;
            sy = LO_DUTY;
            ey = $signed({2'b00, duty_b1_ff});
         end
         SEG_NEG_IN: begin
            sx = b1_x;
            sy = $signed({2'b00, duty_b1_ff});
            ey = $signed({2'b00, duty_n0_ff});
         end
         SEG_POS_IN: begin
            ex = b2_x;
            sy = $signed({2'b00, duty_p0_ff});
            ey = $signed({2'b00, duty_b2_ff});
         end
         SEG_POS_OUT: begin
            sx = b2_x;
            ex = b3_x;
            sy = $signed({2'b00, duty_b2_ff});
            ey = HI_DUTY;
         end
         SEG_LOW: begin
            interp = 1'b0;
            sy     = LO_DUTY;
            ey     = LO_DUTY;
         end
         SEG_HIGH: begin
            interp = 1'b0;
            sy     = HI_DUTY;
            ey     = HI_DUTY;
         end
         default: begin
            interp = 1'b0;
            sy     = MED_DUTY;
            ey     = MED_DUTY;
         end
      endcase
   end

   // Flat segments run as a zero rise over a unit span, so the unbiased quotient is zero
   always_comb begin
      t_full = $signed({x2_ff[X_W-1], x2_ff}) - $signed({sx[X_W-1], sx});
      s_full = $signed({ex[X_W-1], ex}) - $signed({sx[X_W-1], sx});
      t3_in  = interp ? t_full[SPAN_W-1:0] : '0;
      s3_in  = interp ? s_full[SPAN_W-1:0] : SPAN_W'(1);
      dy3_in = $signed({ey[CURVE_W-1], ey}) - $signed({sy[CURVE_W-1], sy});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else if (advance) begin
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t3_ff   <= t3_in;
         s3_ff   <= s3_in;
         dy3_ff  <= dy3_in;
         sy3_ff  <= sy;
         mir3_ff <= mir2_ff;
         ch3_ff  <= ch2_ff;
      end
   end

   //==========================================================================
   // Stage 4: rise times offset
   //==========================================================================
   logic signed [PROD_W-1:0]  prod4_in, prod4_ff;
   logic [SPAN_W-1:0]         s4_ff;
   logic signed [CURVE_W-1:0] sy4_ff;
   logic                      mir4_ff;
   logic [CH_W-1:0]           ch4_ff;
   logic                      vld4_ff;

   assign prod4_in = dy3_ff * $signed({1'b0, t3_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else if (advance) begin
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod4_ff <= prod4_in;
         s4_ff    <= s3_ff;
         sy4_ff   <= sy3_ff;
         mir4_ff  <= mir3_ff;
         ch4_ff   <= ch3_ff;
      end
   end

   //==========================================================================
   // Stage 5: biased numerator 2*rise*offset + span + span*2^QUO_W,
   // divisor 2*span; the bias adds 2^(QUO_W-1) to the floor quotient
   //==========================================================================
   localparam int NF_W = NUM_W + 2;

   logic signed [NF_W-1:0] num_full;
   logic [NUM_W-1:0]       rem_ff [0:QUO_W];
   logic [QUO_W-1:0]       quo_ff [0:QUO_W];
   logic [DVS_W-1:0]       dvs_ff [0:QUO_W];
   logic signed [CURVE_W-1:0] syd_ff [0:QUO_W];
   logic                   mird_ff [0:QUO_W];
   logic [CH_W-1:0]        chd_ff  [0:QUO_W];
   logic                   vldd_ff [0:QUO_W];

   assign num_full = $signed({prod4_ff[PROD_W-1], prod4_ff, 1'b0})
                   + $signed({(NF_W-SPAN_W)'(0), s4_ff})
                   + $signed({(NF_W-SPAN_W-QUO_W)'(0), s4_ff, QUO_W'(0)});

   always_ff @(posedge clock) begin
      if (reset) begin
         vldd_ff[0] <= 1'b0;
      end else if (advance) begin
         vldd_ff[0] <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= num_full[NUM_W-1:0];
         quo_ff[0]  <= '0;
         dvs_ff[0]  <= {s4_ff, 1'b0};
         syd_ff[0]  <= sy4_ff;
         mird_ff[0] <= mir4_ff;
         chd_ff[0]  <= ch4_ff;
      end
   end

   //==========================================================================
   // Divider: one quotient bit per stage, highest first
   //==========================================================================
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int BIT_POS = QUO_W - 1 - k;

      logic [NUM_W-1:0] dvs_sh;
      logic             take;

      assign dvs_sh = NUM_W'(dvs_ff[k]) << BIT_POS;
      assign take   = rem_ff[k] >= dvs_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vldd_ff[k+1] <= 1'b0;
         end else if (advance) begin
            vldd_ff[k+1] <= vldd_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= take ? rem_ff[k] - dvs_sh : rem_ff[k];
            quo_ff[k+1]  <= {quo_ff[k][QUO_W-2:0], take};
            dvs_ff[k+1]  <= dvs_ff[k];
            syd_ff[k+1]  <= syd_ff[k];
            mird_ff[k+1] <= mird_ff[k];
            chd_ff[k+1]  <= chd_ff[k];
         end
      end
   end

   //==========================================================================
   // Output stage: remove the bias, mirror odd channels, clamp
   //==========================================================================
   logic signed [RES_W-1:0] duty_raw, duty_mir;
   logic [DUTY_W-1:0]       cmp_in, cmp_out_ff;
   logic [CH_W-1:0]         ch_out_ff;

   always_comb begin
      duty_raw = $signed({{(RES_W-CURVE_W){syd_ff[QUO_W][CURVE_W-1]}}, syd_ff[QUO_W]})
               + $signed({(RES_W-QUO_W)'(0), quo_ff[QUO_W]})
               - QUO_BIAS;
      duty_mir = mird_ff[QUO_W] ? MIRROR2 - duty_raw : duty_raw;
      if (duty_mir < 0) begin
         cmp_in = '0;
      end else if (duty_mir > $signed({(RES_W-DUTY_W)'(0), {DUTY_W{1'b1}}})) begin
         cmp_in = '1;
      end else begin
         cmp_in = duty_mir[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= vldd_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmp_out_ff <= cmp_in;
         ch_out_ff  <= chd_ff[QUO_W];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {(24-CH_W-DUTY_W)'(0), cmp_out_ff, ch_out_ff};

   //==========================================================================
   // Assertions
   //==========================================================================

   // Quotient of every entering transaction fits the divider
   a_quo_fits: assert property (@(posedge clock) disable iff (reset)
      vldd_ff[0] |-> (rem_ff[0] >> QUO_W) < NUM_W'(dvs_ff[0]))
      else $error("divider numerator overflows quotient width");

   // Final remainder lies below the divisor
   a_rem_done: assert property (@(posedge clock) disable iff (reset)
      vldd_ff[QUO_W] |-> rem_ff[QUO_W] < NUM_W'(dvs_ff[QUO_W]))
      else $error("divider remainder not reduced");

   // Channels beyond the motor count give the median duty
   a_bad_channel: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && ({2'b00, ch_out_ff} >= NUM_CH)) |-> cmp_out_ff == DUTY_W'(MEDIAN_DUTY))
      else $error("out of range channel not at median duty");

   // A held result freezes the pipe
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_tready) |=> ($stable(vld4_ff) && $stable(vldd_ff[QUO_W])
                                        && $stable(cmp_out_ff)))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
